// ----- src/md5_block_compression_assert.svh -----
// Assertion helpers for the MD5 compression block.
`ifndef MD5_BLOCK_COMPRESSION_ASSERT_SVH
`define MD5_BLOCK_COMPRESSION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MD5_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("md5 block: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MD5_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("md5 block: next-cycle check failed");

`endif

// ----- src/md5bc_pkg.sv -----
`timescale 1ns / 1ps

package md5bc_pkg;

	localparam int WORD_W  = 32;
	localparam int INDEX_W = 4;
	localparam int ROUND_W = 6;
	localparam int ROT_W   = 5;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 4 * WORD_W;

	localparam logic [INDEX_W-1:0] LAST_MSG_INDEX = 4'd15;
	localparam logic KIND_CHAIN = 1'b0;
	localparam logic KIND_MSG   = 1'b1;

	localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
	localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
	localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
	localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

	function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] r);
		logic [WORD_W-1:0] k;
		unique case (r)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [ROT_W-1:0] rot_amount(input logic [ROUND_W-1:0] r);
		logic [ROT_W-1:0] s;
		unique case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = '0;
		endcase
		return s;
	endfunction

	// Message word picked by each round, modulo sixteen.
	function automatic logic [INDEX_W-1:0] msg_select(input logic [ROUND_W-1:0] r);
		logic [INDEX_W-1:0] r4;
		logic [INDEX_W-1:0] sel;
		r4 = r[INDEX_W-1:0];
		unique case (r[5:4])
			2'd0: sel = r4;
			2'd1: sel = INDEX_W'(r4 * 4'd5 + 4'd1);
			2'd2: sel = INDEX_W'(r4 * 4'd3 + 4'd5);
			2'd3: sel = INDEX_W'(r4 * 4'd7);
			default: sel = '0;
		endcase
		return sel;
	endfunction

endpackage

// ----- src/md5_block_compression.sv -----
`timescale 1ns / 1ps
`include "md5_block_compression_assert.svh"

// MD5 block compression engine.
// Input channel s_*: one beat either loads a chaining word (tuser = 0, index 0..3;
// indexes above three are dropped) or writes a message word (tuser = 1, index 0..15).
// Chaining and message loads are taken while idle. Writing message word 15 starts a
// compression: the shared round unit (four-input add, rotate, add) runs one round a
// cycle, then a final state folds the working words into the chaining value and
// registers the digest on m_*. s_tready is low from the word-15 beat until the digest
// is registered. All sixteen message words must be written once after reset before the
// first compression; they persist across blocks, as does the chaining value.
// Reset loads the standard initial vector and clears the output valid flag.
// The digest is held in an output register until taken; loads are accepted meanwhile,
// but a following compression waits in its final cycle while m_tready stays low.
module md5_block_compression (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [3:0] word_index, [35:4] word_value, [39:36] zero
	input  logic [md5bc_pkg::S_DATA_W-1:0]      s_tdata,
	// [0] kind
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] digest_a, [63:32] digest_b, [95:64] digest_c, [127:96] digest_d
	output logic [md5bc_pkg::M_DATA_W-1:0]      m_tdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	localparam int W = md5bc_pkg::WORD_W;

	state_t state_q;
	logic [md5bc_pkg::ROUND_W-1:0] round_q;
	logic [W-1:0] chain_q [4];
	logic [W-1:0] a_q, b_q, c_q, d_q;
	logic [W-1:0] msg_q [16];
	logic [W-1:0] msg_rd_q;
	logic [md5bc_pkg::M_DATA_W-1:0] m_data_q;
	logic m_valid_q;

	logic [md5bc_pkg::INDEX_W-1:0] in_index;
	logic [W-1:0] in_value;
	logic s_beat;
	logic start;
	logic [md5bc_pkg::INDEX_W-1:0] rd_addr;
	logic [W-1:0] f_val;
	logic [W-1:0] round_sum;
	logic [2*W-1:0] rot_wide;
	logic [W-1:0] b_next;
	logic [W-1:0] sum_a, sum_b, sum_c, sum_d;
	logic out_free;

	assign in_index = s_tdata[md5bc_pkg::INDEX_W-1:0];
	assign in_value = s_tdata[md5bc_pkg::INDEX_W +: W];
	assign s_tready = (state_q == ST_IDLE);
	assign s_beat   = s_tvalid && s_tready;
	assign start    = s_beat && (s_tuser == md5bc_pkg::KIND_MSG)
		&& (in_index == md5bc_pkg::LAST_MSG_INDEX);
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Fetch one round ahead so the word is registered when its round runs.
	assign rd_addr = (state_q == ST_RUN)
		? md5bc_pkg::msg_select(md5bc_pkg::ROUND_W'(round_q + 6'd1))
		: md5bc_pkg::msg_select('0);

	always_comb begin
		unique case (round_q[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (d_q & b_q) | (~d_q & c_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			2'd3: f_val = c_q ^ (b_q | ~d_q);
			default: f_val = '0;
		endcase
		round_sum = a_q + f_val + md5bc_pkg::round_const(round_q) + msg_rd_q;
		rot_wide  = {round_sum, round_sum} << md5bc_pkg::rot_amount(round_q);
		b_next    = b_q + rot_wide[2*W-1:W];
		sum_a     = chain_q[0] + a_q;
		sum_b     = chain_q[1] + b_q;
		sum_c     = chain_q[2] + c_q;
		sum_d     = chain_q[3] + d_q;
	end

	always_ff @(posedge clk) begin
		if (s_beat && (s_tuser == md5bc_pkg::KIND_MSG)) begin
			msg_q[in_index] <= in_value;
		end
		msg_rd_q <= msg_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			round_q    <= '0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			d_q        <= '0;
			chain_q[0] <= md5bc_pkg::IV_A;
			chain_q[1] <= md5bc_pkg::IV_B;
			chain_q[2] <= md5bc_pkg::IV_C;
			chain_q[3] <= md5bc_pkg::IV_D;
		end else begin
			if (m_valid_q && m_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_beat && (s_tuser == md5bc_pkg::KIND_CHAIN)
						&& (in_index[md5bc_pkg::INDEX_W-1:2] == '0)) begin
						chain_q[in_index[1:0]] <= in_value;
					end
					if (start) begin
						a_q     <= chain_q[0];
						b_q     <= chain_q[1];
						c_q     <= chain_q[2];
						d_q     <= chain_q[3];
						round_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					a_q     <= d_q;
					b_q     <= b_next;
					c_q     <= b_q;
					d_q     <= c_q;
					round_q <= md5bc_pkg::ROUND_W'(round_q + 6'd1);
					if (round_q == '1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the previous digest has been taken
					if (out_free) begin
						chain_q[0] <= sum_a;
						chain_q[1] <= sum_b;
						chain_q[2] <= sum_c;
						chain_q[3] <= sum_d;
						m_data_q   <= {sum_d, sum_c, sum_b, sum_a};
						m_valid_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MD5_ASSERT_NEXT(a_start_blocks, start, !s_tready && (round_q == '0))
	`MD5_ASSERT_NEXT(a_done_emits, (state_q == ST_DONE) && out_free, m_tvalid && s_tready)
	`MD5_ASSERT_NOW(a_rise_after_done, $rose(m_tvalid), $past(state_q == ST_DONE))

endmodule
